// ===== sv/bsw_pkg.sv =====
// Shared types, constants and the header byte table of the 24-bit BMP stream writer.
// Used by every module of the block; depends on nothing else.
package bsw_pkg;

  localparam int unsigned SideW    = 13;
  localparam int unsigned CountW   = 12;
  localparam int unsigned RowBytesW = 14;
  localparam int unsigned FsizeW   = 27;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgIdxW  = 2;

  localparam logic [SideW-1:0] MaxSide = 13'd4096;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 2'd1;

  localparam logic [7:0] CharB        = 8'h42;
  localparam logic [7:0] CharM        = 8'h4d;
  localparam logic [7:0] HdrBytes     = 8'd54;
  localparam logic [7:0] InfoBytes    = 8'h28;
  localparam logic [7:0] BitsPerPixel = 8'd24;
  localparam logic [7:0] Planes       = 8'd1;

  // Byte positions inside the sequence of one pixel.
  localparam logic [IdxW-1:0] IdxBlue  = 6'd54;
  localparam logic [IdxW-1:0] IdxGreen = 6'd55;
  localparam logic [IdxW-1:0] IdxRed   = 6'd56;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       last_of_file;
  } result_t;

  // One classified pixel as handed from the front to the back.
  typedef struct packed {
    logic                 header;
    logic                 file_end;
    logic [1:0]           pad;
    pixel_t               pix;
    logic [RowBytesW-1:0] row_bytes;
    logic [SideW-1:0]     width;
    logic [SideW-1:0]     height;
  } cmd_t;

  function automatic logic [SideW-1:0] clamp_side(input logic [SideW-1:0] v);
    logic [SideW-1:0] r;
    r = v;
    if (v == '0) r = {{(SideW-1){1'b0}}, 1'b1};
    else if (v > MaxSide) r = MaxSide;
    return r;
  endfunction

  // Byte of the 54-byte file header at position idx.
  function automatic logic [7:0] hdr_byte(input logic [IdxW-1:0] idx,
                                          input logic [FsizeW-1:0] fsize,
                                          input logic [SideW-1:0] w,
                                          input logic [SideW-1:0] h);
    logic [31:0] fs;
    logic [15:0] ws;
    logic [15:0] hs;
    logic [7:0]  b;
    fs = {{(32-FsizeW){1'b0}}, fsize};
    ws = {{(16-SideW){1'b0}}, w};
    hs = {{(16-SideW){1'b0}}, h};
    case (idx)
      6'd0:    b = CharB;
      6'd1:    b = CharM;
      6'd2:    b = fs[7:0];
      6'd3:    b = fs[15:8];
      6'd4:    b = fs[23:16];
      6'd5:    b = fs[31:24];
      6'd10:   b = HdrBytes;
      6'd14:   b = InfoBytes;
      6'd18:   b = ws[7:0];
      6'd19:   b = ws[15:8];
      6'd22:   b = hs[7:0];
      6'd23:   b = hs[15:8];
      6'd26:   b = Planes;
      6'd28:   b = BitsPerPixel;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// ===== sv/bmp24_stream_writer_unit.sv =====
// Top level of the 24-bit BMP stream writer: front, command queue and back end.
// Depends on bsw_pkg, bsw_front, bsw_cmd_queue and bsw_back.

// Pixels pushed in stored row order come out as the byte stream of an uncompressed 24-bit BMP
// file, one byte per cycle from the back-end sequencer while its result queue has room, which
// sets the rate: a pixel gives three bytes plus any row-end padding, and the first pixel of
// an image adds the 54 header bytes. The front accepts a pixel in any cycle in which the
// two-entry command queue has room, so pixels enter back to back while earlier ones are still
// being written out. Width and height must be written through the configuration port only
// while idle, not enforced by the block; zero is taken as one and values above 4096 as 4096.
module bmp24_stream_writer_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bsw_pkg::SideW-1:0]     cfg_data_i,
  input  logic                          push,
  output logic                          full,
  input  bsw_pkg::pixel_t               pixel_i,
  output logic                          empty,
  input  logic                          pop,
  output bsw_pkg::result_t              result_o
);
  import bsw_pkg::*;

  cmd_t front_cmd, queue_cmd;
  logic accept, cmd_valid, cmd_rd;

  assign accept = push && !full;

  bsw_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (accept),
    .pixel_i     (pixel_i),
    .cmd_o       (front_cmd)
  );

  bsw_cmd_queue u_cmd_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (accept),
    .wdata_i (front_cmd),
    .full_o  (full),
    .rd_i    (cmd_rd),
    .valid_o (cmd_valid),
    .rdata_o (queue_cmd)
  );

  bsw_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (queue_cmd),
    .cmd_rd_o    (cmd_rd),
    .empty_o     (empty),
    .pop_i       (pop),
    .result_o    (result_o)
  );

endmodule

// ===== sv/bsw_front.sv =====
// Front end of the BMP stream writer: configuration registers, row and column counters,
// and classification of each accepted pixel into a command. Depends on bsw_pkg.
module bsw_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [bsw_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [bsw_pkg::SideW-1:0]     cfg_data_i,
  input  logic                          accept_i,
  input  bsw_pkg::pixel_t               pixel_i,
  output bsw_pkg::cmd_t                 cmd_o
);
  import bsw_pkg::*;

  logic [SideW-1:0]  width_q, height_q;
  logic [CountW-1:0] col_q, col_d, row_q, row_d;
  logic [SideW-1:0]  w_eff, h_eff;
  logic              row_end, file_end;

  assign cfg_ready_o = 1'b1;
  assign w_eff = clamp_side(width_q);
  assign h_eff = clamp_side(height_q);

  assign row_end  = ({1'b0, col_q} + 1'b1) >= w_eff;
  assign file_end = row_end && (({1'b0, row_q} + 1'b1) >= h_eff);

  always_comb begin
    col_d = col_q + 1'b1;
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = file_end ? '0 : row_q + 1'b1;
    end
  end

  // Padding per row equals the low two bits of the width for 3-byte pixels.
  always_comb begin
    cmd_o.header    = (col_q == '0) && (row_q == '0);
    cmd_o.file_end  = file_end;
    cmd_o.pad       = row_end ? w_eff[1:0] : 2'd0;
    cmd_o.pix       = pixel_i;
    cmd_o.row_bytes = {w_eff, 1'b0} + {1'b0, w_eff} + {{(RowBytesW-2){1'b0}}, w_eff[1:0]};
    cmd_o.width     = w_eff;
    cmd_o.height    = h_eff;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= {{(SideW-1){1'b0}}, 1'b1};
      height_q <= {{(SideW-1){1'b0}}, 1'b1};
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      if (cfg_valid_i && cfg_index_i == CfgImageWidth) width_q <= cfg_data_i;
      if (cfg_valid_i && cfg_index_i == CfgImageHeight) height_q <= cfg_data_i;
      if (accept_i) begin
        col_q <= col_d;
        row_q <= row_d;
      end
    end
  end

endmodule

// ===== sv/bsw_cmd_queue.sv =====
// Two-entry command queue between the front and the back of the BMP stream writer.
// Depends on bsw_pkg for the command type.
module bsw_cmd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  bsw_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output bsw_pkg::cmd_t rdata_o
);
  import bsw_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o  = count_q[1];
  assign valid_o = (count_q != 2'd0);
  assign rdata_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr_i) mem_q[wr_ptr_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (wr_i) wr_ptr_q <= ~wr_ptr_q;
      if (rd_i) rd_ptr_q <= ~rd_ptr_q;
      if (wr_i && !rd_i) count_q <= count_q + 2'd1;
      else if (rd_i && !wr_i) count_q <= count_q - 2'd1;
    end
  end

endmodule

// ===== sv/bsw_back.sv =====
// Back end of the BMP stream writer: byte sequencer that expands one command into header,
// pixel and padding bytes, followed by a two-entry result queue. Depends on bsw_pkg.
module bsw_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cmd_valid_i,
  input  bsw_pkg::cmd_t     cmd_i,
  output logic              cmd_rd_o,
  output logic              empty_o,
  input  logic              pop_i,
  output bsw_pkg::result_t  result_o
);
  import bsw_pkg::*;

  cmd_t              cur_q;
  logic              active_q;
  logic [IdxW-1:0]   idx_q;
  logic [FsizeW-1:0] fsize_q;
  logic [IdxW-1:0]   end_idx;
  logic              room, emit, done, load;
  result_t           res;

  result_t           oq_q [2];
  logic              oq_wr_q, oq_rd_q;
  logic [1:0]        oq_cnt_q;
  logic              oq_pop;

  assign end_idx = IdxRed + {{(IdxW-2){1'b0}}, cur_q.pad};
  assign room    = !oq_cnt_q[1];
  assign emit    = active_q && room;
  assign done    = emit && (idx_q == end_idx);
  assign load    = cmd_valid_i && (!active_q || done);
  assign cmd_rd_o = load;

  always_comb begin
    res.out_byte = 8'h00;
    if (idx_q < IdxBlue) res.out_byte = hdr_byte(idx_q, fsize_q, cur_q.width, cur_q.height);
    else if (idx_q == IdxBlue) res.out_byte = cur_q.pix.pixel_blue;
    else if (idx_q == IdxGreen) res.out_byte = cur_q.pix.pixel_green;
    else if (idx_q == IdxRed) res.out_byte = cur_q.pix.pixel_red;
    res.last_of_item = (idx_q == end_idx);
    res.last_of_file = (idx_q == end_idx) && cur_q.file_end;
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q   <= cmd_i;
      fsize_q <= FsizeW'(HdrBytes) + FsizeW'(cmd_i.row_bytes) * FsizeW'(cmd_i.height);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (load) begin
        active_q <= 1'b1;
        idx_q    <= cmd_i.header ? '0 : IdxBlue;
      end else if (done) begin
        active_q <= 1'b0;
      end else if (emit) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  // Result queue so the sequencer keeps running while the consumer stalls, until both entries are full.
  assign empty_o  = (oq_cnt_q == 2'd0);
  assign oq_pop   = pop_i && !empty_o;
  assign result_o = oq_q[oq_rd_q];

  always_ff @(posedge clk_i) begin
    if (emit) oq_q[oq_wr_q] <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (emit) oq_wr_q <= ~oq_wr_q;
      if (oq_pop) oq_rd_q <= ~oq_rd_q;
      if (emit && !oq_pop) oq_cnt_q <= oq_cnt_q + 2'd1;
      else if (oq_pop && !emit) oq_cnt_q <= oq_cnt_q - 2'd1;
    end
  end

endmodule

// ===== sim/tb_bmp24_stream_writer_unit.sv =====
// Self-checking testbench of bmp24_stream_writer_unit: pixels go in, BMP file bytes come out.
// Predicts every byte with its own model of the header, pixel and padding sequence.
// Depends on bsw_pkg and the RTL of bmp24_stream_writer_unit.
`timescale 1ns / 100ps

module tb_bmp24_stream_writer_unit;
  import bsw_pkg::*;

  localparam int unsigned StallLimit  = 4000;
  localparam int unsigned RandomItems = 200;
  localparam int unsigned DrainCycles = 100;

  // Indexes that address no register; writes to them must change nothing.
  localparam logic [CfgIdxW-1:0] CfgNoReg2 = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgNoReg3 = 2'd3;

  logic               clk_i;
  logic               rst_ni      = 1'b0;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [SideW-1:0]   cfg_data_i  = '0;
  logic               push        = 1'b0;
  logic               full;
  pixel_t             pixel_i     = '0;
  logic               empty;
  logic               pop         = 1'b0;
  result_t            result_o;

  // Model state of the writer.
  logic [SideW-1:0] width_reg;
  logic [SideW-1:0] height_reg;
  int unsigned      col_pos;
  int unsigned      row_pos;
  result_t          expected_bytes[$];

  int unsigned errors;
  int unsigned stall_cycles;
  int unsigned pop_hold;
  bit          producer_idle_en;
  bit          consumer_idle_en;

  bmp24_stream_writer_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .full       (full),
    .pixel_i    (pixel_i),
    .empty      (empty),
    .pop        (pop),
    .result_o   (result_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned effective_side(input logic [SideW-1:0] v);
    if (v == '0) return 1;
    if (v > MaxSide) return MaxSide;
    return v;
  endfunction

  // Most gaps are short; a few are long enough to back up the whole pipeline.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Appends the bytes that one accepted pixel causes and advances the counters.
  function automatic void predict_file_bytes(input pixel_t p);
    int unsigned w;
    int unsigned h;
    int unsigned row_bytes;
    int unsigned pad;
    int unsigned fsize;
    logic [7:0]  hdr[54];
    logic [7:0]  seq[$];
    bit          row_end;
    bit          file_end;
    result_t     r;
    w = effective_side(width_reg);
    h = effective_side(height_reg);
    row_bytes = w * 3;
    pad = (4 - (row_bytes % 4)) % 4;
    row_bytes = row_bytes + pad;
    if (col_pos == 0 && row_pos == 0) begin
      fsize = 54 + row_bytes * h;
      foreach (hdr[k]) hdr[k] = 8'h00;
      hdr[0] = CharB;
      hdr[1] = CharM;
      for (int k = 0; k < 4; k++) hdr[2 + k] = 8'(fsize >> (8 * k));
      hdr[10] = HdrBytes;
      hdr[14] = InfoBytes;
      hdr[18] = 8'(w);
      hdr[19] = 8'(w >> 8);
      hdr[22] = 8'(h);
      hdr[23] = 8'(h >> 8);
      hdr[26] = Planes;
      hdr[28] = BitsPerPixel;
      foreach (hdr[k]) seq.push_back(hdr[k]);
    end
    seq.push_back(p.pixel_blue);
    seq.push_back(p.pixel_green);
    seq.push_back(p.pixel_red);
    // A counter at or past the last index closes its row or its image.
    row_end  = (col_pos + 1 >= w);
    file_end = row_end && (row_pos + 1 >= h);
    if (row_end) begin
      repeat (pad) seq.push_back(8'h00);
      col_pos = 0;
      row_pos = file_end ? 0 : ((row_pos + 1) & 32'hfff);
    end else begin
      col_pos = (col_pos + 1) & 32'hfff;
    end
    foreach (seq[k]) begin
      r.out_byte     = seq[k];
      r.last_of_item = (k == seq.size() - 1);
      r.last_of_file = file_end && (k == seq.size() - 1);
      expected_bytes.push_back(r);
    end
  endfunction

  task automatic check_byte(input result_t got);
    result_t want;
    if (expected_bytes.size() == 0) begin
      $display("%0t: byte %h arrived with nothing expected", $time, got.out_byte);
      errors++;
      return;
    end
    want = expected_bytes.pop_front();
    if (got.out_byte !== want.out_byte) begin
      $display("%0t: out_byte expected %h actual %h", $time, want.out_byte, got.out_byte);
      errors++;
    end
    if (got.last_of_item !== want.last_of_item) begin
      $display("%0t: last_of_item expected %b actual %b", $time, want.last_of_item,
               got.last_of_item);
      errors++;
    end
    if (got.last_of_file !== want.last_of_file) begin
      $display("%0t: last_of_file expected %b actual %b", $time, want.last_of_file,
               got.last_of_file);
      errors++;
    end
  endtask

  // Result side: check every transfer, then decide whether to stall.
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) check_byte(result_o);
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold = pop_hold - 1;
    end else begin
      pop <= 1'b1;
      if (consumer_idle_en && $urandom_range(0, 99) < 15) pop_hold = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= StallLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, StallLimit);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Leaves push high on return so that back-to-back pixels need no extra edge.
  task automatic send_pixel(input pixel_t p);
    int unsigned gap;
    gap = (producer_idle_en && $urandom_range(0, 99) < 30) ? pick_gap() : 0;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push    <= 1'b1;
    pixel_i <= p;
    do @(posedge clk_i); while (full);
    predict_file_bytes(p);
  endtask

  task automatic send_random_pixel();
    logic [31:0] r;
    r = $urandom;
    send_pixel(r[23:0]);
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [SideW-1:0] data,
                           input bit last);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (last) cfg_valid_i <= 1'b0;
    if (idx == CfgImageWidth) width_reg = data;
    else if (idx == CfgImageHeight) height_reg = data;
  endtask

  task automatic set_size(input logic [SideW-1:0] w, input logic [SideW-1:0] h);
    cfg_write(CfgImageWidth, w, 1'b0);
    cfg_write(CfgImageHeight, h, 1'b1);
  endtask

  // Sizes after reset are 1 x 1, so every pixel is a whole file.
  task automatic test_reset_defaults();
    send_pixel(24'h000000);
    send_pixel(24'hffffff);
    send_pixel(24'ha55ac3);
    wait_drained();
  endtask

  task automatic test_size_clamping();
    cfg_write(CfgNoReg2, 13'h1fff, 1'b0);
    cfg_write(CfgNoReg3, 13'h1fff, 1'b0);
    set_size(13'd0, 13'd0);
    send_pixel(24'h0f0f0f);
    send_pixel(24'hf0f0f0);
    wait_drained();
    // Oversized values are taken as the maximum side; only the start of the image is sent.
    set_size(13'h1fff, 13'd5000);
    send_pixel(24'h123456);
    send_pixel(24'h789abc);
    send_pixel(24'hdef012);
    wait_drained();
  endtask

  // The column counter now lies beyond the new width, and later the row beyond the height.
  task automatic test_size_change_mid_image();
    cfg_write(CfgImageWidth, 13'd2, 1'b1);
    send_pixel(24'h336699);
    wait_drained();
    set_size(13'd4, 13'd1);
    repeat (4) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_row_padding();
    producer_idle_en = 1'b1;
    consumer_idle_en = 1'b1;
    set_size(13'd3, 13'd2);
    repeat (6) send_random_pixel();
    wait_drained();
    set_size(13'd1, 13'd3);
    repeat (3) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_random_images();
    int unsigned sent;
    int unsigned n;
    int unsigned ew;
    int unsigned eh;
    int unsigned remaining;
    int unsigned pick;
    logic [SideW-1:0] w;
    logic [SideW-1:0] h;
    sent = 0;
    while (sent < RandomItems) begin
      wait_drained();
      producer_idle_en = ($urandom_range(0, 4) != 0);
      consumer_idle_en = ($urandom_range(0, 4) != 0);
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        w = 13'($urandom_range(1, 9));
        h = 13'($urandom_range(1, 4));
      end else if (pick < 90) begin
        w = $urandom_range(0, 1) ? 13'd0 : 13'($urandom_range(4097, 8191));
        h = 13'($urandom_range(0, 3));
      end else begin
        w = 13'($urandom);
        h = 13'($urandom);
      end
      if ($urandom_range(0, 9) == 0) begin
        cfg_write($urandom_range(0, 1) ? CfgNoReg2 : CfgNoReg3, 13'($urandom), 1'b0);
      end
      set_size(w, h);
      ew = effective_side(w);
      eh = effective_side(h);
      // Mostly finish the current file; now and then stop part way through.
      if (col_pos < ew && row_pos < eh) remaining = (eh - row_pos) * ew - col_pos;
      else remaining = ew * eh;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(1, remaining) : remaining;
      if (n > 40) n = $urandom_range(1, 12);
      repeat (n) send_random_pixel();
      sent += n;
    end
  endtask

  initial begin
    errors           = 0;
    pop_hold         = 0;
    stall_cycles     = 0;
    producer_idle_en = 1'b0;
    consumer_idle_en = 1'b0;
    width_reg        = 13'd1;
    height_reg       = 13'd1;
    col_pos          = 0;
    row_pos          = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_size_clamping();
    test_size_change_mid_image();
    test_row_padding();
    test_random_images();

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bsw_pkg.sv
sv/bsw_front.sv
sv/bsw_cmd_queue.sv
sv/bsw_back.sv
sv/bmp24_stream_writer_unit.sv
sim/tb_bmp24_stream_writer_unit.sv
